FILE: rtl/swrt_pkg.sv
// shared types and constants of the sliding window reorder tracker
`timescale 1ns / 1ps

package swrt_pkg;

   // op codes of an input item
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_OPEN = 1'b1;

   // register word index taken from paddr[2]
   localparam logic REG_WINDOW_SIZE = 1'b0;

   localparam int SEQ_W  = 16;
   localparam int WIN_W  = 6;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = 6'd16;

   typedef enum logic [2:0] {
      KIND_DELIVER       = 3'd0,
      KIND_OUT_OF_WINDOW = 3'd1,
      KIND_DUPLICATE     = 3'd2,
      KIND_OOO_DUPLICATE = 3'd3,
      KIND_PENDING       = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             op;
      logic [SEQ_W-1:0] packet_number;
      logic [SEQ_W-1:0] read_number;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [SEQ_W-1:0] seq_number;
      logic [SEQ_W-1:0] receipt_number;
      logic             last;
   } rsp_type;

   // verdict of the classifier on one data packet
   typedef struct packed {
      kind_type kind;
      logic     in_order;
      logic     store;
   } class_type;

endpackage

FILE: rtl/swrt_classify.sv
// verdict on one data packet: window check, duplicate check, pending map lookup
`timescale 1ns / 1ps

module swrt_classify #(
   parameter int WINDOW_MAX = 32
) (
   input  swrt_pkg::req_type                   req,
   input  logic [swrt_pkg::SEQ_W-1:0]          last_in_order,
   input  logic [WINDOW_MAX-1:0]               pending_map,
   input  logic [swrt_pkg::WIN_W-1:0]          window_size,
   output swrt_pkg::class_type                 verdict,
   output logic [WINDOW_MAX-1:0]               store_mask
);
   import swrt_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);

   logic [SEQ_W-1:0] limit;
   logic [SEQ_W-1:0] d_win;
   logic [SEQ_W-1:0] d_lio;
   logic [SEQ_W-1:0] off;
   logic [IDX_W-1:0] off_idx;
   logic             beyond_window;
   logic             after_lio;

   assign limit         = req.read_number + {{(SEQ_W-WIN_W){1'b0}}, window_size};
   assign d_win         = req.packet_number - limit;
   assign d_lio         = req.packet_number - last_in_order;
   assign off           = d_lio - 16'd1;
   assign off_idx       = off[IDX_W-1:0];
   assign beyond_window = (d_win != '0) && !d_win[SEQ_W-1];
   assign after_lio     = (d_lio != '0) && !d_lio[SEQ_W-1];
   assign store_mask    = {{(WINDOW_MAX-1){1'b0}}, 1'b1} << off_idx;

   always_comb begin
      verdict = '{kind: KIND_DUPLICATE, in_order: 1'b0, store: 1'b0};
      if (beyond_window) begin
         verdict.kind = KIND_OUT_OF_WINDOW;
      end else if (!after_lio) begin
         verdict.kind = KIND_DUPLICATE;
      end else if (off == '0) begin
         verdict.kind     = KIND_DELIVER;
         verdict.in_order = 1'b1;
      end else if (off >= SEQ_W'(WINDOW_MAX)) begin
         // inside the window but past what the map can hold
         verdict.kind = KIND_OUT_OF_WINDOW;
      end else if (pending_map[off_idx]) begin
         verdict.kind = KIND_OOO_DUPLICATE;
      end else begin
         verdict.kind  = KIND_PENDING;
         verdict.store = 1'b1;
      end
   end

endmodule

FILE: rtl/sliding_window_reorder_tracker.sv
// top level of the sliding window receive reorder tracker
`timescale 1ns / 1ps

// Receive-side packet sequencing for one connection. An open item sets the
// last in-order number and clears the pending map without a result. A data
// item yields one result, except a next-in-order packet, which yields itself
// followed by every pending successor, each on its own transfer, all carrying
// the final receipt number, the last one flagged. One item is in the block at
// a time; req_stall is high from acceptance until its final result transfer.
// An item with one result is accepted, then its result is shown from the output
// registers and held there while rsp_stall is high. For an in-order packet
// releasing k pending successors, the pending map is first walked by one
// shared shift-and-increment step, one bit per cycle, to find the run length
// (and so the receipt number) before the first result is shown; then the
// k + 1 results go out one per cycle while rsp_stall is low, from a seq counter.
module sliding_window_reorder_tracker #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  swrt_pkg::req_type             req_payload,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output swrt_pkg::rsp_type             rsp_payload,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swrt_pkg::ADDR_W-1:0]   paddr,
   input  logic [swrt_pkg::DATA_W-1:0]   pwdata,
   output logic [swrt_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import swrt_pkg::*;

   // a released run holds at most WINDOW_MAX-1 successors
   localparam int CNT_W = $clog2(WINDOW_MAX);

   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        lio_ff, lio_in;
   logic [WINDOW_MAX-1:0]   map_ff, map_in;
   logic [WIN_W-1:0]        win_ff, win_in;
   kind_type                kind_ff, kind_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [CNT_W-1:0]        run_ff, run_in;

   class_type               verdict;
   logic [WINDOW_MAX-1:0]   store_mask;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    cfg_write;

   swrt_classify #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_classify (
      .req           (req_payload),
      .last_in_order (lio_ff),
      .pending_map   (map_ff),
      .window_size   (win_ff),
      .verdict       (verdict),
      .store_mask    (store_mask)
   );

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // result comes straight from registers, stable while stalled;
   // lio_ff already holds the final receipt number in the emit state
   assign rsp_payload = '{kind:           kind_ff,
                          seq_number:     seq_ff,
                          receipt_number: lio_ff,
                          last:           (run_ff == '0)};

   // register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ?
                      {{(DATA_W-WIN_W){1'b0}}, win_ff} : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_payload.op == OP_DATA)) begin
               // a run only when the successor of the delivered packet waits
               state_in = (verdict.in_order && map_ff[1]) ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (!map_ff[1]) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer && (run_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      lio_in  = lio_ff;
      map_in  = map_ff;
      win_in  = win_ff;
      kind_in = kind_ff;
      seq_in  = seq_ff;
      run_in  = run_ff;

      if (cfg_write && (paddr[2] == REG_WINDOW_SIZE)) begin
         win_in = pwdata[WIN_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_payload.op == OP_OPEN) begin
                  lio_in = req_payload.packet_number;
                  map_in = '0;
               end else begin
                  kind_in = verdict.kind;
                  seq_in  = req_payload.packet_number;
                  run_in  = '0;
                  if (verdict.in_order) begin
                     lio_in = req_payload.packet_number;
                     map_in = {1'b0, map_ff[WINDOW_MAX-1:1]};
                  end else if (verdict.store) begin
                     map_in = map_ff | store_mask;
                  end
               end
            end
         end
         ST_SCAN: begin
            // shared step: consume one pending bit, advance the in-order mark
            map_in = {1'b0, map_ff[WINDOW_MAX-1:1]};
            lio_in = lio_ff + 16'd1;
            run_in = run_ff + CNT_W'(1);
         end
         ST_EMIT: begin
            if (rsp_xfer && (run_ff != '0)) begin
               seq_in = seq_ff + 16'd1;
               run_in = run_ff - CNT_W'(1);
            end
         end
         default: begin
            run_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lio_ff   <= '0;
         map_ff   <= '0;
         win_ff   <= WINDOW_SIZE_RESET;
         run_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lio_ff   <= lio_in;
         map_ff   <= map_in;
         win_ff   <= win_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      seq_ff  <= seq_in;
   end

   // bit 0 of the map is set only while a run is being walked
   a_map_bit0_scan : assert property (@(posedge clock) disable iff (reset)
      map_ff[0] == (state_ff == ST_SCAN))
      else $error("pending map bit 0 out of step with scan");

   // each scan step moves the in-order mark by exactly one
   a_scan_advance : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (lio_ff == $past(lio_ff) + 16'd1))
      else $error("scan step did not advance last in-order number");

   // within a run the sequence climbs by one and the receipt holds
   a_run_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_payload.last) |=>
         (rsp_valid && (rsp_payload.seq_number == $past(rsp_payload.seq_number) + 16'd1)
          && $stable(rsp_payload.receipt_number)))
      else $error("released run out of order");

   // the final transfer of an item frees the input side
   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_payload.last) |=> (state_ff == ST_IDLE))
      else $error("block not idle after final result");

endmodule
